FILE: src/avr_pkg.sv
// ============================================================================
// avr_pkg: shared definitions for the vector rotation block
// Widths, fixed-point constants, axis codes, the arctangent table and the
// structures handed between the CORDIC cells and the output stage.
// ============================================================================
package avr_pkg;

    localparam int COORD_BITS    = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int ANGLE_BITS    = 16;
    localparam int GUARD         = 12;

    // Rotation datapath: coordinate, guard bits, negation and CORDIC growth.
    localparam int DATA_W  = COORD_BITS + GUARD + 3;
    // Q5.30 angle accumulator, input angles reach about +-4 rad.
    localparam int ANG_W   = 35;
    localparam int ANG_SHIFT = 17;
    localparam int STAGE_W = 5;
    localparam int OUT_W   = COORD_BITS + 1;

    localparam int IN_TDATA_W  = ((3 * COORD_BITS + ANGLE_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((3 * OUT_W + 7) / 8) * 8;

    localparam int INV_GAIN = 652032874;
    localparam int INV_HI   = INV_GAIN / 32768;
    localparam int INV_LO   = INV_GAIN % 32768;
    localparam int PROD_W   = DATA_W + 16;
    localparam int SUM_W    = PROD_W + 1;
    localparam int LO_SHIFT = 15;
    localparam int RND_SHIFT = 15 + GUARD;

    localparam logic signed [ANG_W-1:0] PI_Q30      = ANG_W'(64'sd3373259426);
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = ANG_W'(64'sd1686629713);

    localparam logic [1:0] MODE_X   = 2'd0;
    localparam logic [1:0] MODE_Y   = 2'd1;
    localparam logic [1:0] MODE_Z   = 2'd2;
    localparam logic [1:0] MODE_BAD = 2'd3;

    localparam logic [29:0] ATAN_TAB [32] = '{
        30'd843314857, 30'd497837829, 30'd263043836, 30'd133525159,
        30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
        30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
        30'd262144,    30'd131072,    30'd65536,     30'd32768,
        30'd16384,     30'd8192,      30'd4096,      30'd2048,
        30'd1024,      30'd512,       30'd256,       30'd128,
        30'd64,        30'd32,        30'd16,        30'd8,
        30'd4,         30'd2,         30'd1,         30'd0
    };

    function automatic logic signed [ANG_W-1:0] atan_q30(input logic [STAGE_W-1:0] idx);
        atan_q30 = ANG_W'(ATAN_TAB[idx]);
    endfunction

    typedef struct packed {
        logic signed [DATA_W-1:0]     p;
        logic signed [DATA_W-1:0]     q;
        logic signed [ANG_W-1:0]      ang;
        logic [1:0]                   mode;
        logic signed [COORD_BITS-1:0] pass;
    } t_cell_data;

    typedef struct packed {
        logic signed [OUT_W-1:0] rot_x;
        logic signed [OUT_W-1:0] rot_y;
        logic signed [OUT_W-1:0] rot_z;
        logic                    bad_axis;
    } t_result;

endpackage

FILE: src/avr_cordic_cell.sv
// ============================================================================
// avr_cordic_cell: one CORDIC micro-rotation
// Rotates the pair toward zero residual angle by atan(2^-i) and registers
// the pair, the residual angle and the sideband for the next cell.
// ============================================================================
module avr_cordic_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic [avr_pkg::STAGE_W-1:0] i_stage,
    input  logic                  i_valid,
    input  avr_pkg::t_cell_data   i_data,
    output logic                  o_valid,
    output avr_pkg::t_cell_data   o_data
);
    import avr_pkg::*;

    logic        r_valid;
    t_cell_data  r_data;
    t_cell_data  n_data;
    logic signed [DATA_W-1:0] dp;
    logic signed [DATA_W-1:0] dq;
    logic signed [ANG_W-1:0]  da;

    always_comb begin
        dp = i_data.q >>> i_stage;
        dq = i_data.p >>> i_stage;
        da = atan_q30(i_stage);
        n_data = i_data;
        if (!i_data.ang[ANG_W-1]) begin
            n_data.p   = i_data.p - dp;
            n_data.q   = i_data.q + dq;
            n_data.ang = i_data.ang - da;
        end else begin
            n_data.p   = i_data.p + dp;
            n_data.q   = i_data.q - dq;
            n_data.ang = i_data.ang + da;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: src/avr_finish.sv
// ============================================================================
// avr_finish: gain compensation, rounding, saturation and axis routing
// Two pipeline steps: the split gain products, then sum, round, clamp and
// placement of the rotated pair and the passed coordinate.
// ============================================================================
module avr_finish (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  avr_pkg::t_cell_data i_data,
    output logic                o_valid,
    output avr_pkg::t_result    o_result
);
    import avr_pkg::*;

    localparam logic signed [15:0] HI_C = 16'(INV_HI);
    localparam logic signed [15:0] LO_C = 16'(INV_LO);

    logic                     r_valid_a;
    logic signed [PROD_W-1:0] r_hi_a, r_lo_a, r_hi_b, r_lo_b;
    logic [1:0]               r_mode;
    logic signed [COORD_BITS-1:0] r_pass;

    logic      r_valid;
    t_result   r_result;
    t_result   n_result;
    logic signed [OUT_W-1:0] res_a, res_b, pass_ext;

    function automatic logic signed [OUT_W-1:0] round_sat(
        input logic signed [PROD_W-1:0] hi,
        input logic signed [PROD_W-1:0] lo
    );
        logic signed [SUM_W-1:0] t;
        logic signed [SUM_W-1:0] r;
        logic signed [SUM_W-1:0] lim_hi;
        logic signed [SUM_W-1:0] lim_lo;
        t = SUM_W'(hi) + SUM_W'(lo >>> LO_SHIFT);
        r = (t + (SUM_W'(1) <<< (RND_SHIFT - 1))) >>> RND_SHIFT;
        lim_hi = (SUM_W'(1) <<< COORD_BITS) - SUM_W'(1);
        lim_lo = -(SUM_W'(1) <<< COORD_BITS);
        if (r > lim_hi) begin
            r = lim_hi;
        end else if (r < lim_lo) begin
            r = lim_lo;
        end
        round_sat = r[OUT_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid   <= 1'b0;
        end else if (i_en) begin
            r_valid_a <= i_valid;
            r_valid   <= r_valid_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hi_a <= PROD_W'(i_data.p) * PROD_W'(HI_C);
            r_lo_a <= PROD_W'(i_data.p) * PROD_W'(LO_C);
            r_hi_b <= PROD_W'(i_data.q) * PROD_W'(HI_C);
            r_lo_b <= PROD_W'(i_data.q) * PROD_W'(LO_C);
            r_mode <= i_data.mode;
            r_pass <= i_data.pass;
        end
    end

    always_comb begin
        res_a    = round_sat(r_hi_a, r_lo_a);
        res_b    = round_sat(r_hi_b, r_lo_b);
        pass_ext = OUT_W'(r_pass);
        n_result = '0;
        case (r_mode)
            MODE_X: begin
                n_result.rot_x = pass_ext;
                n_result.rot_y = res_a;
                n_result.rot_z = res_b;
            end
            MODE_Y: begin
                n_result.rot_y = pass_ext;
                n_result.rot_z = res_a;
                n_result.rot_x = res_b;
            end
            MODE_Z: begin
                n_result.rot_z = pass_ext;
                n_result.rot_x = res_a;
                n_result.rot_y = res_b;
            end
            default: begin
                n_result.bad_axis = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

FILE: src/axis_vector_rotation.sv
// ============================================================================
// axis_vector_rotation: rotate a 3D vector about the x, y or z axis
// Streaming CORDIC rotator with pre-rotation, gain compensation and an
// output skid buffer.
// ============================================================================
// The block takes one item per clock while o_s_axis_tready is high and
// delivers one result per item, in order. An accepted item passes the
// pre-rotation register, which loads at the accepting edge, then the chain
// of CORDIC cells, two gain-compensation steps and the output register.
// The whole pipeline advances together; a two-entry output buffer lets an
// item enter while a finished result waits, and o_s_axis_tready drops only
// when both entries are full. Axis code 3 gives zero coordinates with the
// error flag set in o_m_axis_tuser.
module axis_vector_rotation (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // vec_x, vec_y, vec_z, turn_angle (lowest bits first)
    input  logic [avr_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // mode
    input  logic [1:0]                        i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // rot_x, rot_y, rot_z, zero padding (lowest bits first)
    output logic [avr_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    // bad_axis
    output logic                              o_m_axis_tuser
);
    import avr_pkg::*;

    logic en;
    logic signed [COORD_BITS-1:0] vec_x, vec_y, vec_z;
    logic signed [ANGLE_BITS-1:0] turn_angle;
    logic signed [COORD_BITS-1:0] a_in, b_in;
    logic signed [ANG_W-1:0]      ang_full;
    t_cell_data n_prep;
    t_cell_data r_prep;
    logic       r_prep_valid;

    t_cell_data chain_data  [CORDIC_STAGES+1];
    logic       chain_valid [CORDIC_STAGES+1];

    logic    fin_valid;
    t_result fin_result;

    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;
    logic    out_take;

    assign en = !r_skid_valid;
    assign o_s_axis_tready = en;

    assign vec_x      = i_s_axis_tdata[COORD_BITS-1:0];
    assign vec_y      = i_s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign vec_z      = i_s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign turn_angle = i_s_axis_tdata[3*COORD_BITS+ANGLE_BITS-1:3*COORD_BITS];

    // Pick the rotated pair and the coordinate that passes through.
    always_comb begin
        case (i_s_axis_tuser)
            MODE_X: begin
                a_in = vec_y;
                b_in = vec_z;
                n_prep.pass = vec_x;
            end
            MODE_Y: begin
                a_in = vec_z;
                b_in = vec_x;
                n_prep.pass = vec_y;
            end
            MODE_Z: begin
                a_in = vec_x;
                b_in = vec_y;
                n_prep.pass = vec_z;
            end
            default: begin
                a_in = '0;
                b_in = '0;
                n_prep.pass = '0;
            end
        endcase
        n_prep.mode = i_s_axis_tuser;
        ang_full = ANG_W'(turn_angle) <<< ANG_SHIFT;
        n_prep.p = DATA_W'(a_in) <<< GUARD;
        n_prep.q = DATA_W'(b_in) <<< GUARD;
        n_prep.ang = ang_full;
        // Angles beyond a quarter turn start from the opposite half plane.
        if (ang_full > HALF_PI_Q30) begin
            n_prep.p   = -n_prep.p;
            n_prep.q   = -n_prep.q;
            n_prep.ang = ang_full - PI_Q30;
        end else if (ang_full < -HALF_PI_Q30) begin
            n_prep.p   = -n_prep.p;
            n_prep.q   = -n_prep.q;
            n_prep.ang = ang_full + PI_Q30;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep_valid <= 1'b0;
        end else if (en) begin
            r_prep_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prep <= n_prep;
        end
    end

    assign chain_data[0]  = r_prep;
    assign chain_valid[0] = r_prep_valid;

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
        avr_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_stage (STAGE_W'(k)),
            .i_valid (chain_valid[k]),
            .i_data  (chain_data[k]),
            .o_valid (chain_valid[k+1]),
            .o_data  (chain_data[k+1])
        );
    end

    avr_finish u_finish (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (chain_valid[CORDIC_STAGES]),
        .i_data   (chain_data[CORDIC_STAGES]),
        .o_valid  (fin_valid),
        .o_result (fin_result)
    );

    assign out_take = r_out_valid && i_m_axis_tready;

    // Output register with a skid entry behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (fin_valid) begin
            if (!r_out_valid || out_take) begin
                r_out       <= fin_result;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= fin_result;
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'({r_out.rot_z, r_out.rot_y, r_out.rot_x});
    assign o_m_axis_tuser  = r_out.bad_axis;

endmodule

FILE: src/avr_checker.sv
// ============================================================================
// avr_checker: port-level checks for the vector rotation block
// Watches the streaming ports of the top level; attached by bind.
// ============================================================================
module avr_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_axis_tvalid,
    input logic                             o_s_axis_tready,
    input logic [avr_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    input logic [1:0]                       i_s_axis_tuser,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [avr_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    input logic                             o_m_axis_tuser
);
    import avr_pkg::*;

    localparam int PAD_LO = 3 * OUT_W;

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled output changed");

    // A bad axis code gives an all-zero vector.
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("bad axis result is not zero");

    // Padding above the three coordinates stays zero.
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[OUT_TDATA_W-1:PAD_LO] == '0)
        else $error("output padding not zero");

    // Reset empties the pipeline and the output buffer.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("reset did not clear the output side");

endmodule

bind axis_vector_rotation avr_checker u_avr_checker (.*);
